FILE: rtl/mcw_pkg.sv
// ---------------------------------------------------------------------------
// mcw_pkg
// Shared types for the minimum covering window block: beat layouts,
// operation codes, controller states and memory control groups.
// ---------------------------------------------------------------------------
package mcw_pkg;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_END     = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] symbol;
    } t_in_beat;

    typedef struct packed {
        logic        found;
        logic [11:0] window_start;
        logic [12:0] window_length;
        logic        overflow;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAT,
        ST_TXT,
        ST_CHK,
        ST_SRD,
        ST_SUPD
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_cnt_ctl;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_txt_ctl;

endpackage

FILE: rtl/mcw_text_mem.sv
// ---------------------------------------------------------------------------
// mcw_text_mem
// Text buffer: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mcw_text_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 8
) (
    input  logic             i_clk,
    input  mcw_pkg::t_txt_ctl i_ctl,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [DW-1:0]    i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [DW-1:0]    o_rd_data
);
    import mcw_pkg::*;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mcw_count_mem.sv
// ---------------------------------------------------------------------------
// mcw_count_mem
// Per-symbol need/have counts with a valid bit per entry; an entry
// that is not valid reads as zero. Clear drops every valid bit at once.
// ---------------------------------------------------------------------------
module mcw_count_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcw_pkg::t_cnt_ctl i_ctl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [DW-1:0]    i_wr_data,
    output logic [DW-1:0]    o_rd_data
);
    import mcw_pkg::*;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rd_data;
    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: rtl/minimum_covering_window.sv
// ---------------------------------------------------------------------------
// minimum_covering_window
// Shortest text window covering every pattern symbol with multiplicity.
//
//   channel | signals                             | payload
//   --------+-------------------------------------+-----------
//   in      | i_in_valid  / o_in_ready            | t_in_beat
//   out     | o_out_valid / i_out_ready           | t_out_beat
//
// Pattern beat: count memory read, then write back.
// Text beat: buffer write and count read, count write back, check; every
//   symbol dropped from the left adds a text read, count read and a count
//   write back with check. End beat: the result sits in an output register.
// Reset and end of job clear the count valid bits at once; no clearing pass.
// A result not yet taken holds the input side off only in the idle state.
// ---------------------------------------------------------------------------
module minimum_covering_window #(
    parameter int MAX_TEXT = 4096,
    parameter int ALPHABET = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mcw_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mcw_pkg::t_out_beat o_out_data
);
    import mcw_pkg::*;

    localparam int POS_W  = $clog2(MAX_TEXT + 1);
    localparam int ADDR_W = $clog2(MAX_TEXT);
    localparam int SYM_W  = $clog2(ALPHABET);
    localparam int KIND_W = $clog2(ALPHABET + 1);
    localparam int CNT_DW = 2 * POS_W;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_left, n_left;
    logic [POS_W-1:0]   r_right, n_right;
    logic [POS_W-1:0]   r_plen, n_plen;
    logic [KIND_W-1:0]  r_kneed, n_kneed;
    logic [KIND_W-1:0]  r_ksat, n_ksat;
    logic [POS_W-1:0]   r_best_len, n_best_len;
    logic [ADDR_W-1:0]  r_best_start, n_best_start;
    logic               r_ovf, n_ovf;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    logic [SYM_W-1:0]   w_mod_tbl [256];
    logic [SYM_W-1:0]   w_sym;
    logic               w_acc;
    logic               w_cover;
    logic [POS_W-1:0]   w_len;
    logic [POS_W-1:0]   w_need;
    logic [POS_W-1:0]   w_have;
    logic [CNT_DW-1:0]  w_cnt_rd;
    logic [CNT_DW-1:0]  w_cnt_wdata;
    logic [SYM_W-1:0]   w_cnt_raddr;
    logic [SYM_W-1:0]   w_txt_rd;
    logic [ADDR_W-1:0]  w_txt_raddr;
    t_cnt_ctl           w_cnt_ctl;
    t_txt_ctl           w_txt_ctl;

    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_mod_tbl[g] = SYM_W'(g % ALPHABET);
    end

    assign w_sym      = w_mod_tbl[i_in_data.symbol];
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_need     = w_cnt_rd[CNT_DW-1:POS_W];
    assign w_have     = w_cnt_rd[POS_W-1:0];
    assign w_len      = r_right - r_left;
    assign w_cover    = (r_kneed != '0) && (r_ksat == r_kneed) && (r_left < r_right);

    mcw_count_mem #(
        .DEPTH (ALPHABET),
        .AW    (SYM_W),
        .DW    (CNT_DW)
    ) u_cnt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_cnt_ctl),
        .i_rd_addr (w_cnt_raddr),
        .i_wr_addr (r_sym),
        .i_wr_data (w_cnt_wdata),
        .o_rd_data (w_cnt_rd)
    );

    mcw_text_mem #(
        .DEPTH (MAX_TEXT),
        .AW    (ADDR_W),
        .DW    (SYM_W)
    ) u_txt (
        .i_clk     (i_clk),
        .i_ctl     (w_txt_ctl),
        .i_wr_addr (r_right[ADDR_W-1:0]),
        .i_wr_data (w_sym),
        .i_rd_addr (w_txt_raddr),
        .o_rd_data (w_txt_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_data.operation == OP_PATTERN) begin
                        if (r_right == '0 && r_plen < POS_W'(MAX_TEXT)) begin
                            n_state = ST_PAT;
                        end
                    end else if (i_in_data.operation == OP_TEXT) begin
                        if (r_right < POS_W'(MAX_TEXT)) begin
                            n_state = ST_TXT;
                        end
                    end
                end
            end
            ST_PAT:  n_state = ST_IDLE;
            ST_TXT:  n_state = ST_CHK;
            ST_CHK:  n_state = w_cover ? ST_SRD : ST_IDLE;
            ST_SRD:  n_state = ST_SUPD;
            ST_SUPD: n_state = ST_CHK;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_left       = r_left;
        n_right      = r_right;
        n_plen       = r_plen;
        n_kneed      = r_kneed;
        n_ksat       = r_ksat;
        n_best_len   = r_best_len;
        n_best_start = r_best_start;
        n_ovf        = r_ovf;
        n_sym        = r_sym;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_cnt_ctl    = '0;
        w_txt_ctl    = '0;
        w_cnt_raddr  = w_sym;
        w_cnt_wdata  = w_cnt_rd;
        w_txt_raddr  = r_left[ADDR_W-1:0];
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_in_data.operation == OP_PATTERN) begin
                        if (r_right == '0) begin
                            if (r_plen < POS_W'(MAX_TEXT)) begin
                                w_cnt_ctl.rd_en = 1'b1;
                                n_sym           = w_sym;
                                n_plen          = r_plen + POS_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                    end else if (i_in_data.operation == OP_TEXT) begin
                        if (r_right < POS_W'(MAX_TEXT)) begin
                            w_txt_ctl.wr_en = 1'b1;
                            w_cnt_ctl.rd_en = 1'b1;
                            n_sym           = w_sym;
                            n_right         = r_right + POS_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (i_in_data.operation == OP_END) begin
                        n_out_valid         = 1'b1;
                        n_out.found         = (r_best_len != '0);
                        n_out.window_start  = (r_best_len != '0) ? 12'(r_best_start) : '0;
                        n_out.window_length = 13'(r_best_len);
                        n_out.overflow      = r_ovf;
                        w_cnt_ctl.clr       = 1'b1;
                        n_left              = '0;
                        n_right             = '0;
                        n_plen              = '0;
                        n_kneed             = '0;
                        n_ksat              = '0;
                        n_best_len          = '0;
                        n_best_start        = '0;
                        n_ovf               = 1'b0;
                    end
                end
            end
            ST_PAT: begin
                w_cnt_ctl.wr_en = 1'b1;
                w_cnt_wdata     = {w_need + POS_W'(1), w_have};
                if (w_need == '0) begin
                    n_kneed = r_kneed + KIND_W'(1);
                end
            end
            ST_TXT: begin
                if (w_need != '0) begin
                    w_cnt_ctl.wr_en = 1'b1;
                    w_cnt_wdata     = {w_need, w_have + POS_W'(1)};
                    if (w_have + POS_W'(1) == w_need) begin
                        n_ksat = r_ksat + KIND_W'(1);
                    end
                end
            end
            ST_CHK: begin
                if (w_cover) begin
                    if (r_best_len == '0 || w_len < r_best_len) begin
                        n_best_len   = w_len;
                        n_best_start = r_left[ADDR_W-1:0];
                    end
                    w_txt_ctl.rd_en = 1'b1;
                    n_left          = r_left + POS_W'(1);
                end
            end
            ST_SRD: begin
                w_cnt_ctl.rd_en = 1'b1;
                w_cnt_raddr     = w_txt_rd;
                n_sym           = w_txt_rd;
            end
            ST_SUPD: begin
                if (w_need != '0) begin
                    w_cnt_ctl.wr_en = 1'b1;
                    w_cnt_wdata     = {w_need, (w_have != '0) ? w_have - POS_W'(1) : w_have};
                    if (w_have == w_need) begin
                        n_ksat = r_ksat - KIND_W'(1);
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_left       <= '0;
            r_right      <= '0;
            r_plen       <= '0;
            r_kneed      <= '0;
            r_ksat       <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_left       <= n_left;
            r_right      <= n_right;
            r_plen       <= n_plen;
            r_kneed      <= n_kneed;
            r_ksat       <= n_ksat;
            r_best_len   <= n_best_len;
            r_best_start <= n_best_start;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_sat_le_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ksat <= r_kneed)
        else $error("satisfied kinds exceed needed kinds");

    a_left_le_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_right)
        else $error("window left edge passed right edge");

    a_best_le_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_len <= r_right)
        else $error("best window longer than text taken");

    a_end_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.operation == OP_END) |=> o_out_valid)
        else $error("end beat produced no result");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum covering window block. A scoreboard
// class tracks pattern counts, window counts and the best window of the
// current job, queues the result each end beat should produce and compares
// every output beat field by field. Short directed jobs and random jobs,
// about 1500 beats in all, run under random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_top;
    import mcw_pkg::*;

    localparam int TEXT_DEPTH = 4096;
    localparam int SYMBOLS = 256;
    localparam int IDLE_LIMIT = 60000;
    localparam int LONG_HOLD = 400;
    localparam logic [1:0] OP_NONE = 2'd3;

    class window_tracker;
        logic [12:0] need_cnt [SYMBOLS];
        logic [12:0] have_cnt [SYMBOLS];
        logic [7:0]  text_mem [TEXT_DEPTH];
        logic [12:0] left_idx;
        logic [12:0] right_idx;
        logic [12:0] pat_len;
        logic [12:0] best_len;
        logic [11:0] best_pos;
        logic [8:0]  kinds_need;
        logic [8:0]  kinds_met;
        logic        ovf;
        t_out_beat   expected_windows [$];
        int          mismatches;
        int          results_seen;
        int          found_seen;
        int          overflow_seen;

        function new();
            mismatches = 0;
            results_seen = 0;
            found_seen = 0;
            overflow_seen = 0;
            clear_job();
        endfunction

        function void clear_job();
            foreach (need_cnt[i]) begin
                need_cnt[i] = '0;
                have_cnt[i] = '0;
            end
            left_idx = '0;
            right_idx = '0;
            pat_len = '0;
            best_len = '0;
            best_pos = '0;
            kinds_need = '0;
            kinds_met = '0;
            ovf = 1'b0;
        endfunction

        function void add_pattern(logic [7:0] sym);
            if (right_idx != 0) return;
            if (pat_len >= TEXT_DEPTH) begin
                ovf = 1'b1;
                return;
            end
            pat_len++;
            if (need_cnt[sym] == 0) kinds_need++;
            need_cnt[sym]++;
        endfunction

        function void add_text(logic [7:0] sym);
            logic [12:0] span;
            logic [7:0]  gone;
            if (right_idx >= TEXT_DEPTH) begin
                ovf = 1'b1;
                return;
            end
            text_mem[right_idx[11:0]] = sym;
            right_idx++;
            if (need_cnt[sym] != 0) begin
                have_cnt[sym]++;
                if (have_cnt[sym] == need_cnt[sym]) kinds_met++;
            end
            // shrink from the left while every needed kind is covered
            while (kinds_need != 0 && kinds_met == kinds_need && left_idx < right_idx) begin
                span = right_idx - left_idx;
                if (best_len == 0 || span < best_len) begin
                    best_len = span;
                    best_pos = left_idx[11:0];
                end
                gone = text_mem[left_idx[11:0]];
                left_idx++;
                if (need_cnt[gone] != 0) begin
                    if (have_cnt[gone] == need_cnt[gone]) kinds_met--;
                    if (have_cnt[gone] != 0) have_cnt[gone]--;
                end
            end
        endfunction

        function void take_beat(t_in_beat b);
            t_out_beat w;
            case (b.operation)
                OP_PATTERN: add_pattern(b.symbol);
                OP_TEXT:    add_text(b.symbol);
                OP_END: begin
                    w.found = (best_len != 0);
                    w.window_start = w.found ? best_pos : '0;
                    w.window_length = w.found ? best_len : '0;
                    w.overflow = ovf;
                    expected_windows.push_back(w);
                    clear_job();
                end
                default: ;
            endcase
        endfunction

        function void match_field(string name, logic [12:0] want, logic [12:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_window(t_out_beat got);
            t_out_beat want;
            results_seen++;
            if (expected_windows.size() == 0) begin
                $display("%0t: unexpected result found=%0d start=%0d length=%0d overflow=%0d",
                         $time, got.found, got.window_start, got.window_length, got.overflow);
                mismatches++;
                return;
            end
            want = expected_windows.pop_front();
            if (want.found) found_seen++;
            if (want.overflow) overflow_seen++;
            match_field("found", 13'(want.found), 13'(got.found));
            match_field("window_start", 13'(want.window_start), 13'(got.window_start));
            match_field("window_length", want.window_length, got.window_length);
            match_field("overflow", 13'(want.overflow), 13'(got.overflow));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    window_tracker tracker = new();
    int  beats_sent = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    bit  long_hold_req = 1'b0;

    minimum_covering_window dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic idle_sender();
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [7:0] sym);
        t_in_beat b;
        b.operation = op;
        b.symbol = sym;
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        tracker.take_beat(b);
        if (op != OP_NONE) beats_sent++;
        idle_sender();
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (tracker.expected_windows.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_job();
        int          pat_n;
        int          txt_n;
        int          span;
        logic [7:0]  base;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 15))
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            send_beat(OP_END, 8'($urandom_range(0, 255)));
            return;
        end
        pat_n = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 4);
        txt_n = $urandom_range(0, 40);
        span = $urandom_range(2, 6);
        base = 8'($urandom_range(0, 255));
        repeat (pat_n) send_beat(OP_PATTERN, base + 8'($urandom_range(0, span - 1)));
        repeat (txt_n) begin
            if ($urandom_range(0, 99) < 4) send_beat(OP_NONE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 3)
                send_beat(OP_PATTERN, base + 8'($urandom_range(0, span - 1)));
            send_beat(OP_TEXT, base + 8'($urandom_range(0, span - 1)));
        end
        send_beat(OP_END, 8'($urandom_range(0, 255)));
    endtask

    // output side: random stalls, ready stretches and one long hold-off
    initial begin
        int r;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end else if (r < 90) begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else if (r < 97) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(30, 100)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            tracker.compare_window(o_out_data);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int job;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty job
        send_beat(OP_END, 8'h00);
        // extreme symbols with repeats
        send_beat(OP_PATTERN, 8'h00);
        send_beat(OP_PATTERN, 8'hFF);
        send_beat(OP_PATTERN, 8'hFF);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'h12);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_END, 8'hFF);
        // late pattern symbol and an unknown operation
        send_beat(OP_PATTERN, 8'h41);
        send_beat(OP_TEXT, 8'h42);
        send_beat(OP_PATTERN, 8'h42);
        send_beat(OP_NONE, 8'hC3);
        send_beat(OP_TEXT, 8'h41);
        send_beat(OP_END, 8'h00);
        // pattern without text
        send_beat(OP_PATTERN, 8'h80);
        send_beat(OP_END, 8'h00);
        // text with empty pattern
        send_beat(OP_TEXT, 8'h7F);
        send_beat(OP_TEXT, 8'h01);
        send_beat(OP_END, 8'h00);
        // pattern symbol absent from text
        send_beat(OP_PATTERN, 8'h33);
        send_beat(OP_TEXT, 8'h34);
        send_beat(OP_TEXT, 8'h35);
        send_beat(OP_END, 8'h00);
        wait_results();

        job = 0;
        while (beats_sent < 1500) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (job == 10) long_hold_req = 1'b1;
            if (job == 40) wait_results();
            random_job();
            job++;
        end
        no_gaps = 1'b0;
        wait_results();

        repeat (50) @(posedge i_clk);
        $display("Covered %0d jobs over %0d beats: %0d windows found, %0d with overflow.",
                 tracker.results_seen, beats_sent, tracker.found_seen, tracker.overflow_seen);
        $display("Included empty and late patterns, unknown operations and a long output stall.");
        if (tracker.mismatches == 0 && tracker.expected_windows.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", tracker.mismatches,
                     tracker.expected_windows.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
